>>> sv/xmodem_crc_block_receiver_macros.svh
// Assertion macros shared by the checker
`ifndef XMODEM_CRC_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_CRC_BLOCK_RECEIVER_MACROS_SVH

// overlapping implication, sampled on the rising edge, off during reset
`define XCBR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication into the following cycle
`define XCBR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/xcbr_pkg.sv
`default_nettype none
package xcbr_pkg;

	localparam int BLOCK_BYTES = 128;
	localparam int REM_W       = 5;
	localparam int WORDS       = BLOCK_BYTES / 8;

	localparam logic [2:0] KIND_ACK  = 3'd0;
	localparam logic [2:0] KIND_NACK = 3'd1;
	localparam logic [2:0] KIND_WORD = 3'd2;
	localparam logic [2:0] KIND_INT  = 3'd3;
	localparam logic [2:0] KIND_EXT  = 3'd4;
	localparam logic [2:0] KIND_DONE = 3'd5;

	localparam logic [1:0] CFG_BASE = 2'd0;
	localparam logic [1:0] CFG_EXT  = 2'd1;
	localparam logic [1:0] CFG_SLOT = 2'd2;

	typedef enum logic [1:0] {
		JOB_NACK = 2'd0,
		JOB_GOOD = 2'd1,
		JOB_EOT  = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic              bank;
		logic [REM_W-1:0]  rem;
		logic [15:0]       page;
		logic [15:0]       blocks;
	} job_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [2:0]  lane;
		logic [7:0]  data;
	} mem_wr_t;

endpackage
`default_nettype wire

>>> sv/xcbr_queue.sv
`default_nettype none
module xcbr_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire xcbr_pkg::job_t push_job,
	input  wire logic           pop,
	output logic                full,
	output logic                not_empty,
	output xcbr_pkg::job_t      head
);

	xcbr_pkg::job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule
`default_nettype wire

>>> sv/xcbr_front.sv
`default_nettype none
module xcbr_front #(
	parameter int PAGE_BYTES = 1024
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            command,
	input  wire logic [7:0]      rx_byte,
	input  wire logic            frame_end,
	input  wire logic            q_full,
	output logic                 push,
	output xcbr_pkg::job_t       push_job,
	output xcbr_pkg::mem_wr_t    mem_wr
);

	localparam int PER_PAGE = PAGE_BYTES / xcbr_pkg::BLOCK_BYTES;
	localparam logic [xcbr_pkg::REM_W-1:0] REM_LAST = xcbr_pkg::REM_W'(PER_PAGE - 1);

	logic                        session_q;
	logic [7:0]                  fbc_q;
	logic [7:0]                  first_q;
	logic [15:0]                 crc_q;
	logic [7:0]                  rcrc_hi_q;
	logic [15:0]                 blocks_q;
	logic [xcbr_pkg::REM_W-1:0]  rem_q;
	logic [15:0]                 page_q;
	logic                        bank_q;

	logic        acc;
	logic        in_payload;
	logic [6:0]  pidx;
	logic        good_frame;
	logic        eot_frame;
	logic        crc_ok;
	logic [15:0] blocks_nx;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		return c;
	endfunction

	assign in_stall   = q_full;
	assign acc        = in_valid && !q_full;
	assign in_payload = (fbc_q >= 8'd3) && (fbc_q < 8'd131);
	assign pidx       = 7'(fbc_q - 8'd3);
	assign crc_ok     = (crc_q == {rcrc_hi_q, rx_byte});
	assign good_frame = (fbc_q == 8'd132) && (first_q == 8'h01);
	assign eot_frame  = (fbc_q == 8'd0) && (rx_byte == 8'h04);
	assign blocks_nx  = blocks_q + 16'd1;

	always_comb begin
		mem_wr.en   = acc && !command && in_payload;
		mem_wr.addr = {bank_q, pidx[6:3]};
		mem_wr.lane = pidx[2:0];
		mem_wr.data = rx_byte;

		push_job.bank   = bank_q;
		push_job.rem    = rem_q;
		push_job.page   = page_q;
		push_job.blocks = blocks_q;
		push_job.kind   = xcbr_pkg::JOB_NACK;
		push = 1'b0;
		if (acc && !command && frame_end && session_q) begin
			if (good_frame) begin
				push          = 1'b1;
				push_job.kind = crc_ok ? xcbr_pkg::JOB_GOOD : xcbr_pkg::JOB_NACK;
			end else if (eot_frame) begin
				push          = 1'b1;
				push_job.kind = xcbr_pkg::JOB_EOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= 1'b0;
			fbc_q     <= 8'd0;
			first_q   <= 8'd0;
			crc_q     <= 16'd0;
			rcrc_hi_q <= 8'd0;
			blocks_q  <= 16'd0;
			rem_q     <= '0;
			page_q    <= 16'd0;
			bank_q    <= 1'b0;
		end else if (acc) begin
			if (command) begin
				session_q <= 1'b1;
				blocks_q  <= 16'd0;
				rem_q     <= '0;
				page_q    <= 16'd0;
				fbc_q     <= 8'd0;
			end else begin
				if (fbc_q == 8'd0) begin
					first_q <= rx_byte;
					crc_q   <= 16'd0;
				end
				if (in_payload)
					crc_q <= crc_byte(crc_q, rx_byte);
				if (fbc_q == 8'd131)
					rcrc_hi_q <= rx_byte;
				if (frame_end)
					fbc_q <= 8'd0;
				else if (fbc_q != 8'hFF)
					fbc_q <= fbc_q + 8'd1;
				if (push && push_job.kind == xcbr_pkg::JOB_GOOD) begin
					blocks_q <= blocks_nx;
					bank_q   <= ~bank_q;
					// page position restarts when the block counter wraps
					if (blocks_nx == 16'd0) begin
						rem_q  <= '0;
						page_q <= 16'd0;
					end else if (rem_q == REM_LAST) begin
						rem_q  <= '0;
						page_q <= page_q + 16'd1;
					end else begin
						rem_q <= rem_q + 1'b1;
					end
				end
				if (push && push_job.kind == xcbr_pkg::JOB_EOT)
					session_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> sv/xcbr_back.sv
`default_nettype none
module xcbr_back #(
	parameter int PAGE_BYTES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_data,
	input  wire logic              job_valid,
	input  wire xcbr_pkg::job_t    job,
	output logic                   pop,
	input  wire xcbr_pkg::mem_wr_t mem_wr,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             kind,
	output logic [63:0]            payload_word,
	output logic [31:0]            target_address,
	output logic [10:0]            byte_count,
	output logic [23:0]            image_bytes,
	output logic                   last
);

	localparam int PER_PAGE = PAGE_BYTES / xcbr_pkg::BLOCK_BYTES;
	localparam logic [xcbr_pkg::REM_W-1:0] REM_LAST = xcbr_pkg::REM_W'(PER_PAGE - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_WORD  = 7'b0000100,
		ST_PAGE  = 7'b0001000,
		ST_ACK   = 7'b0010000,
		ST_NACK  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t      state_q, state_nx;
	logic [3:0]  wcnt_q;
	logic [1:0]  pcnt_q;
	logic [31:0] base_q;
	logic        ext_q;
	logic [3:0]  slot_q;
	logic [63:0] mem [32];
	logic [63:0] rd_q;

	logic        valid_q;
	logic [2:0]  kind_q;
	logic [63:0] word_q;
	logic [31:0] addr_q;
	logic [10:0] cnt_q;
	logic [23:0] img_q;
	logic        last_q;

	logic        can_emit;
	logic        emit;
	logic [2:0]  r_kind;
	logic [63:0] r_word;
	logic [31:0] r_addr;
	logic [10:0] r_cnt;
	logic [23:0] r_img;
	logic        r_last;
	logic        is_good;
	logic        page_full;
	logic [31:0] page_addr;
	logic [31:0] ext_addr;

	assign out_valid      = valid_q;
	assign kind           = kind_q;
	assign payload_word   = word_q;
	assign target_address = addr_q;
	assign byte_count     = cnt_q;
	assign image_bytes    = img_q;
	assign last           = last_q;

	assign can_emit  = !valid_q || !out_stall;
	assign is_good   = (job.kind == xcbr_pkg::JOB_GOOD);
	assign page_full = (job.rem == REM_LAST);
	assign page_addr = base_q + 32'(job.page) * 32'(PAGE_BYTES);
	assign ext_addr  = {20'd0, slot_q, 8'd0} + {14'd0, job.page, 2'd0} + {30'd0, pcnt_q};

	always_ff @(posedge clk) begin
		if (mem_wr.en)
			mem[mem_wr.addr][mem_wr.lane*8 +: 8] <= mem_wr.data;
		rd_q <= mem[{job.bank, wcnt_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd0;
			ext_q  <= 1'b0;
			slot_q <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				xcbr_pkg::CFG_BASE: base_q <= cfg_data;
				xcbr_pkg::CFG_EXT:  ext_q  <= cfg_data[0];
				xcbr_pkg::CFG_SLOT: slot_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_nx = state_q;
		emit     = 1'b0;
		pop      = 1'b0;
		r_kind   = xcbr_pkg::KIND_ACK;
		r_word   = 64'd0;
		r_addr   = 32'd0;
		r_cnt    = 11'd0;
		r_img    = 24'd0;
		r_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					unique case (job.kind)
						xcbr_pkg::JOB_GOOD: state_nx = ST_FETCH;
						xcbr_pkg::JOB_EOT:  state_nx = ST_ACK;
						default:            state_nx = ST_NACK;
					endcase
				end
			end
			ST_FETCH: state_nx = ST_WORD;
			ST_WORD: begin
				if (can_emit) begin
					emit     = 1'b1;
					r_kind   = xcbr_pkg::KIND_WORD;
					r_word   = rd_q;
					r_addr   = {20'd0, job.rem, 7'd0} + {25'd0, wcnt_q, 3'd0};
					if (wcnt_q == 4'(xcbr_pkg::WORDS - 1))
						state_nx = page_full ? ST_PAGE : ST_ACK;
					else
						state_nx = ST_FETCH;
				end
			end
			ST_PAGE: begin
				if (can_emit) begin
					emit = 1'b1;
					if (ext_q) begin
						r_kind = xcbr_pkg::KIND_EXT;
						r_addr = ext_addr;
					end else begin
						r_kind = xcbr_pkg::KIND_INT;
						r_addr = page_addr;
						r_cnt  = is_good ? 11'(PAGE_BYTES) : {job.rem[3:0], 7'd0};
					end
					if (!ext_q || pcnt_q == 2'd3)
						state_nx = is_good ? ST_ACK : ST_DONE;
				end
			end
			ST_ACK: begin
				if (can_emit) begin
					emit   = 1'b1;
					r_kind = xcbr_pkg::KIND_ACK;
					r_last = is_good;
					if (is_good) begin
						pop      = 1'b1;
						state_nx = ST_IDLE;
					end else begin
						state_nx = (job.rem != '0) ? ST_PAGE : ST_DONE;
					end
				end
			end
			ST_NACK: begin
				if (can_emit) begin
					emit     = 1'b1;
					r_kind   = xcbr_pkg::KIND_NACK;
					r_last   = 1'b1;
					pop      = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (can_emit) begin
					emit     = 1'b1;
					r_kind   = xcbr_pkg::KIND_DONE;
					r_img    = {1'b0, job.blocks, 7'd0};
					r_last   = 1'b1;
					pop      = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wcnt_q  <= 4'd0;
			pcnt_q  <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_IDLE) begin
				wcnt_q <= 4'd0;
				pcnt_q <= 2'd0;
			end
			if (emit && state_q == ST_WORD)
				wcnt_q <= wcnt_q + 4'd1;
			if (emit && state_q == ST_PAGE)
				pcnt_q <= pcnt_q + 2'd1;
			if (can_emit)
				valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= r_kind;
			word_q <= r_word;
			addr_q <= r_addr;
			cnt_q  <= r_cnt;
			img_q  <= r_img;
			last_q <= r_last;
		end
	end

endmodule
`default_nettype wire

>>> sv/xmodem_crc_block_receiver.sv
// Flow: a frame's last byte pushes a job into a two-entry queue; the back end takes it
// from the queue and registers each result. A good block gives 16 payload words (one
// buffer read each), then its page writes when the page is full, and then the ACK.
// Throughput: 1 byte per cycle while fewer than two frame results are pending.
// Reset: asynchronous, active low; clears session, counters, queue and output valid.
`default_nettype none
module xmodem_crc_block_receiver #(
	parameter int PAGE_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [63:0]      payload_word,
	output logic [31:0]      target_address,
	output logic [10:0]      byte_count,
	output logic [23:0]      image_bytes,
	output logic             last
);

	logic              q_full;
	logic              q_not_empty;
	logic              push;
	logic              pop;
	xcbr_pkg::job_t    push_job;
	xcbr_pkg::job_t    head;
	xcbr_pkg::mem_wr_t mem_wr;

	xcbr_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job),
		.mem_wr    (mem_wr)
	);

	xcbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	xcbr_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.job_valid      (q_not_empty),
		.job            (head),
		.pop            (pop),
		.mem_wr         (mem_wr),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.payload_word   (payload_word),
		.target_address (target_address),
		.byte_count     (byte_count),
		.image_bytes    (image_bytes),
		.last           (last)
	);

endmodule
`default_nettype wire

>>> sv/xcbr_checker.sv
`default_nettype none
`include "xmodem_crc_block_receiver_macros.svh"
module xcbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  kind,
	input wire logic [63:0] payload_word,
	input wire logic        last
);

	`XCBR_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind) && $stable(payload_word) && $stable(last), "stalled result changed")
	`XCBR_ASSERT_IMP(a_kind, clk, arst_n, out_valid, kind <= xcbr_pkg::KIND_DONE, "result kind out of range")
	`XCBR_ASSERT_IMP(a_word_zero, clk, arst_n, out_valid && kind != xcbr_pkg::KIND_WORD, payload_word == 64'd0, "payload on non-word result")
	`XCBR_ASSERT_IMP(a_word_last, clk, arst_n, out_valid && kind == xcbr_pkg::KIND_WORD, !last, "payload word closed a transaction")

endmodule

bind xmodem_crc_block_receiver xcbr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.payload_word (payload_word),
	.last         (last)
);
`default_nettype wire

>>> bench/xmodem_crc_block_receiver_checker.sv
module xmodem_crc_block_receiver_checker #(
	parameter int PAGE_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  kind,
	input  logic [63:0] payload_word,
	input  logic [31:0] target_address,
	input  logic [10:0] byte_count,
	input  logic [23:0] image_bytes,
	input  logic        last,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCKS_PER_PAGE = PAGE_BYTES / 128;

	typedef struct {
		logic [2:0]  kind;
		logic [63:0] word;
		logic [31:0] addr;
		logic [10:0] cnt;
		logic [23:0] img;
		logic        last;
	} flash_result_t;

	flash_result_t flash_results_due[$];
	flash_result_t step_results[$];

	logic [31:0] base_addr;
	logic        ext_en;
	logic [3:0]  slot;
	logic        in_session;
	logic [7:0]  byte_pos;
	logic [7:0]  first_b;
	logic [15:0] crc_run;
	logic [15:0] crc_rx;
	logic [7:0]  block_buf [128];
	logic [15:0] blocks;

	function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
		c = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	task automatic add_result(logic [2:0] k, logic [63:0] w, logic [31:0] a,
			logic [10:0] n, logic [23:0] img);
		flash_result_t r;
		r.kind = k; r.word = w; r.addr = a; r.cnt = n; r.img = img; r.last = 1'b0;
		step_results.push_back(r);
	endtask

	task automatic add_page_write(logic [31:0] pidx, logic [31:0] len);
		if (ext_en) begin
			for (int i = 0; i < 4; i++)
				add_result(xcbr_pkg::KIND_EXT, 64'd0,
					{28'd0, slot} * 32'd256 + pidx * 32'd4 + i, 11'd0, 24'd0);
		end else begin
			add_result(xcbr_pkg::KIND_INT, 64'd0, base_addr + pidx * PAGE_BYTES,
				len[10:0], 24'd0);
		end
	endtask

	task automatic predict_byte(logic cmd, logic [7:0] b, logic fe);
		logic [7:0] pos;
		logic [31:0] nxt, rem, offset;
		logic [63:0] w;
		if (cmd) begin
			in_session = 1'b1;
			blocks = 16'd0;
			byte_pos = 8'd0;
			return;
		end
		pos = byte_pos;
		if (pos == 0) begin
			first_b = b;
			crc_run = 16'd0;
		end
		if (pos >= 3 && pos < 131) begin
			block_buf[pos - 3] = b;
			crc_run = crc16_next(crc_run, b);
		end else if (pos == 131) begin
			crc_rx[15:8] = b;
		end else if (pos == 132) begin
			crc_rx[7:0] = b;
		end
		if (byte_pos != 8'd255)
			byte_pos++;
		if (!fe)
			return;
		byte_pos = 8'd0;
		if (!in_session)
			return;
		if (pos == 132 && first_b == 8'h01) begin
			if (crc_run != crc_rx) begin
				add_result(xcbr_pkg::KIND_NACK, 64'd0, 32'd0, 11'd0, 24'd0);
			end else begin
				offset = (blocks % BLOCKS_PER_PAGE) * 128;
				for (int i = 0; i < 16; i++) begin
					for (int k = 0; k < 8; k++)
						w[8*k +: 8] = block_buf[i*8 + k];
					add_result(xcbr_pkg::KIND_WORD, w, offset + i*8, 11'd0, 24'd0);
				end
				nxt = blocks + 1;
				if (nxt % BLOCKS_PER_PAGE == 0)
					add_page_write(nxt / BLOCKS_PER_PAGE - 1, PAGE_BYTES);
				blocks = nxt[15:0];
				add_result(xcbr_pkg::KIND_ACK, 64'd0, 32'd0, 11'd0, 24'd0);
			end
		end else if (pos == 0 && b == 8'h04) begin
			rem = blocks % BLOCKS_PER_PAGE;
			add_result(xcbr_pkg::KIND_ACK, 64'd0, 32'd0, 11'd0, 24'd0);
			if (rem != 0)
				add_page_write(blocks / BLOCKS_PER_PAGE, rem * 128);
			nxt = blocks * 128;
			add_result(xcbr_pkg::KIND_DONE, 64'd0, 32'd0, 11'd0, nxt[23:0]);
			in_session = 1'b0;
		end
	endtask

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		flash_result_t r;
		if (!arst_n) begin
			errors = 0;
			base_addr = 32'd0;
			ext_en = 1'b0;
			slot = 4'd1;
			in_session = 1'b0;
			byte_pos = 8'd0;
			first_b = 8'd0;
			crc_run = 16'd0;
			crc_rx = 16'd0;
			blocks = 16'd0;
			flash_results_due.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					xcbr_pkg::CFG_BASE: base_addr = cfg_data;
					xcbr_pkg::CFG_EXT:  ext_en = cfg_data[0];
					xcbr_pkg::CFG_SLOT: slot = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				step_results.delete();
				predict_byte(command, rx_byte, frame_end);
				if (step_results.size() > 0) begin
					step_results[step_results.size() - 1].last = 1'b1;
					foreach (step_results[i])
						flash_results_due.push_back(step_results[i]);
				end
			end
			if (out_valid && !out_stall) begin
				if (flash_results_due.size() == 0) begin
					$error("unexpected result: kind %0d addr %h", kind, target_address);
					errors++;
				end else begin
					r = flash_results_due.pop_front();
					check_field("kind", r.kind, kind);
					check_field("payload_word", r.word, payload_word);
					check_field("target_address", r.addr, target_address);
					check_field("byte_count", r.cnt, byte_count);
					check_field("image_bytes", r.img, image_bytes);
					check_field("last", r.last, last);
				end
			end
		end
		pending = flash_results_due.size();
	end

endmodule

>>> bench/xmodem_crc_block_receiver_tb.sv
module xmodem_crc_block_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = xcbr_pkg::CFG_BASE;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [63:0] payload_word;
	logic [31:0] target_address;
	logic [10:0] byte_count;
	logic [23:0] image_bytes;
	logic        last;
	int          errors;
	int          pending;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          cycle_cnt = 0;
	logic [7:0]  frame_q[$];

	xmodem_crc_block_receiver dut (.*);

	xmodem_crc_block_receiver_checker chk (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [15:0] crc16_next(logic [15:0] c, logic [7:0] b);
		c = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
		return c;
	endfunction

	// one input transaction, entered and left at a falling edge
	task automatic send(logic cmd, logic [7:0] b, logic fe);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= b;
		frame_end <= fe;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic xmit_frame();
		foreach (frame_q[i])
			send(1'b0, frame_q[i], i == frame_q.size() - 1);
	endtask

	// fill: 0 random, 1 all zero, 2 all ones
	task automatic block_frame(int fill, logic corrupt);
		logic [15:0] crc;
		logic [7:0] blk, d;
		int idx;
		crc = 16'd0;
		blk = $urandom_range(255);
		frame_q = {8'h01, blk, ~blk};
		for (int i = 0; i < 128; i++) begin
			d = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : $urandom_range(255);
			frame_q.push_back(d);
			crc = crc16_next(crc, d);
		end
		frame_q.push_back(crc[15:8]);
		frame_q.push_back(crc[7:0]);
		if (corrupt) begin
			idx = $urandom_range(132, 3);
			frame_q[idx] = frame_q[idx] ^ (8'd1 << $urandom_range(7));
		end
		xmit_frame();
	endtask

	// frames that must give nothing
	task automatic junk_frame(int shape);
		int len;
		case (shape)
			0: len = 1;
			1: len = $urandom_range(132, 2);
			2: len = 133;
			3: len = 134;
			default: len = 300;
		endcase
		frame_q = {};
		for (int i = 0; i < len; i++)
			frame_q.push_back($urandom_range(255));
		if (len == 1 && frame_q[0] == 8'h04)
			frame_q[0] = 8'h05;
		if (len == 133 && frame_q[0] == 8'h01)
			frame_q[0] = 8'h02;
		if (len > 133)
			frame_q[0] = 8'h01;
		xmit_frame();
	endtask

	task automatic eot_frame();
		frame_q = {8'h04};
		xmit_frame();
	endtask

	task automatic cfg_wr(logic [1:0] idx, logic [31:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		// frames with no answer may still be in flight
		repeat (60) @(negedge clk);
	endtask

	task automatic run_session(int nblk);
		int goods, r;
		goods = 0;
		send(1'b1, $urandom_range(255), $urandom_range(1));
		while (goods < nblk) begin
			r = $urandom_range(99);
			if (r < 10) begin
				block_frame(0, 1'b1);
			end else if (r < 18) begin
				junk_frame($urandom_range(4));
			end else begin
				block_frame($urandom_range(99) < 10 ? $urandom_range(2, 1) : 0, 1'b0);
				goods++;
			end
		end
		eot_frame();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no session yet: nothing comes back until a command opens one
		block_frame(0, 1'b0);
		eot_frame();
		send(1'b1, 8'hFF, 1'b1);
		junk_frame(0);
		junk_frame(2);
		junk_frame(4);
		block_frame(1, 1'b0);
		block_frame(2, 1'b0);
		block_frame(0, 1'b1);
		frame_q = {8'h04, 8'h00};
		xmit_frame();
		eot_frame();
		eot_frame();
		settle();

		for (int s = 0; s < 12; s++) begin
			case (s % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 86; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 86; end
				default: begin idle_pct = 24; stall_pct = 24; end
			endcase
			cfg_wr(xcbr_pkg::CFG_BASE,
				(s % 3 == 0) ? 32'd0 : (s % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
			cfg_wr(xcbr_pkg::CFG_EXT, (s / 2) % 2);
			cfg_wr(xcbr_pkg::CFG_SLOT,
				(s % 4 == 0) ? 32'd1 : (s % 4 == 1) ? 32'd9 : $urandom_range(9, 1));
			run_session((s < 4) ? 8 * (s % 2 + 1) : $urandom_range(12));
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
